### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and defaults for the stable priority queue
// Holds the command codes, the per-cell control group and the default sizes.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Default sizes
  localparam int DEPTH_DEF          = 16;
  localparam int VALUE_WIDTH_DEF    = 32;
  localparam int PRIORITY_WIDTH_DEF = 16;

  // Command codes carried on in_kind
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_POP    = 1'b1
  } spq_kind_t;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic shift_in;   // accepted insert: open a gap and drop the new entry in
    logic shift_out;  // accepted pop: everything moves one cell to the front
  } spq_ctrl_t;

endpackage

### design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift row
// Holds one entry, compares it with the incoming key and takes the new entry,
// its left neighbor or its right neighbor on a shift.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
  input  logic                             clk,
  input  spq_ctrl_t                        ctrl,
  input  logic                             occupied,
  input  logic signed [PRIORITY_WIDTH-1:0] key,
  input  logic        [VALUE_WIDTH-1:0]    new_value,
  input  logic                             left_behind,
  input  logic signed [PRIORITY_WIDTH-1:0] left_priority,
  input  logic        [VALUE_WIDTH-1:0]    left_value,
  input  logic signed [PRIORITY_WIDTH-1:0] right_priority,
  input  logic        [VALUE_WIDTH-1:0]    right_value,
  output logic                             behind,
  output logic signed [PRIORITY_WIDTH-1:0] priority_q,
  output logic        [VALUE_WIDTH-1:0]    value_q
);

  logic signed [PRIORITY_WIDTH-1:0] priority_r;
  logic        [VALUE_WIDTH-1:0]    value_r;

  // New entry belongs in front of this slot: slot empty or strictly larger
  assign behind = !occupied || (priority_r > key);

  // Insert: first behind slot takes the new entry, later ones shift right.
  // Pop: every slot takes its right neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.shift_in && behind) begin
      if (left_behind) begin
        priority_r <= left_priority;
        value_r    <= left_value;
      end else begin
        priority_r <= key;
        value_r    <= new_value;
      end
    end else if (ctrl.shift_out) begin
      priority_r <= right_priority;
      value_r    <= right_value;
    end
  end

  assign priority_q = priority_r;
  assign value_q    = value_r;

endmodule

### design/stable_priority_queue.sv
// The out_strobe beat of a result comes in the cycle after its accepted start.
// Throughput: one command per cycle; busy stays low, every slot shifts at once.
// Each command makes exactly one result beat; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the queue and clears out_strobe.
// Slot contents are not cleared; slots beyond the fill count are never read.
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded sorted priority queue
// A row of cells keeps entries sorted smallest priority first; equal
// priorities leave in arrival order. Insert and pop each yield one result beat.
// ----------------------------------------------------------------------------
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH          = DEPTH_DEF,
  parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_kind,
  input  logic signed [PRIORITY_WIDTH-1:0] in_priority_req,
  input  logic        [VALUE_WIDTH-1:0]    in_value,
  output logic                             out_strobe,
  output logic                             out_pop_valid,
  output logic signed [PRIORITY_WIDTH-1:0] out_priority,
  output logic        [VALUE_WIDTH-1:0]    out_value,
  output logic                             out_empty_res,
  output logic                             out_full_res,
  output logic                             out_error
);

  localparam int CW = $clog2(DEPTH + 1);

  // Fill count and result registers
  logic [CW-1:0]                    count_r, count_nxt;
  logic                             strobe_r, strobe_nxt;
  logic                             pop_valid_r, pop_valid_nxt;
  logic signed [PRIORITY_WIDTH-1:0] priority_r, priority_nxt;
  logic        [VALUE_WIDTH-1:0]    value_r, value_nxt;
  logic                             empty_r, empty_nxt;
  logic                             full_r, full_nxt;
  logic                             error_r, error_nxt;

  logic      accept, is_pop, q_empty, q_full, ins_ok, pop_ok;
  spq_ctrl_t ctrl;

  logic                             behind_w   [DEPTH];
  logic signed [PRIORITY_WIDTH-1:0] priority_w [DEPTH];
  logic        [VALUE_WIDTH-1:0]    value_w    [DEPTH];

  // Every cycle can take a command
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign is_pop = (in_kind == KIND_POP);

  assign q_empty = (count_r == '0);
  assign q_full  = (count_r == CW'(DEPTH));
  assign ins_ok  = accept && !is_pop && !q_full;
  assign pop_ok  = accept && is_pop && !q_empty;

  assign ctrl.shift_in  = ins_ok;
  assign ctrl.shift_out = pop_ok;

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                             occ;
    logic                             l_behind;
    logic signed [PRIORITY_WIDTH-1:0] l_pri, r_pri;
    logic        [VALUE_WIDTH-1:0]    l_val, r_val;

    assign occ = (CW'(i) < count_r);

    if (i == 0) begin : g_head
      assign l_behind = 1'b0;
      assign l_pri    = in_priority_req;
      assign l_val    = in_value;
    end else begin : g_mid
      assign l_behind = behind_w[i-1];
      assign l_pri    = priority_w[i-1];
      assign l_val    = value_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_pri = priority_w[i];
      assign r_val = value_w[i];
    end else begin : g_body
      assign r_pri = priority_w[i+1];
      assign r_val = value_w[i+1];
    end

    spq_cell #(
      .VALUE_WIDTH    (VALUE_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk            (clk),
      .ctrl           (ctrl),
      .occupied       (occ),
      .key            (in_priority_req),
      .new_value      (in_value),
      .left_behind    (l_behind),
      .left_priority  (l_pri),
      .left_value     (l_val),
      .right_priority (r_pri),
      .right_value    (r_val),
      .behind         (behind_w[i]),
      .priority_q     (priority_w[i]),
      .value_q        (value_w[i])
    );
  end

  // Count update and result beat
  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CW'(1);
    end
    strobe_nxt    = accept;
    pop_valid_nxt = pop_ok;
    priority_nxt  = pop_ok ? priority_w[0] : '0;
    value_nxt     = pop_ok ? value_w[0] : '0;
    empty_nxt     = (count_nxt == '0);
    full_nxt      = (count_nxt == CW'(DEPTH));
    error_nxt     = accept && (is_pop ? q_empty : q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      strobe_r    <= 1'b0;
      pop_valid_r <= 1'b0;
      error_r     <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      strobe_r    <= strobe_nxt;
      pop_valid_r <= pop_valid_nxt;
      error_r     <= error_nxt;
    end
  end

  always_ff @(posedge clk) begin
    priority_r <= priority_nxt;
    value_r    <= value_nxt;
    empty_r    <= empty_nxt;
    full_r     <= full_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_pop_valid = pop_valid_r;
  assign out_priority  = priority_r;
  assign out_value     = value_r;
  assign out_empty_res = empty_r;
  assign out_full_res  = full_r;
  assign out_error     = error_r;

`ifndef SYNTHESIS
  // Fill count never passes the row length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count above depth");

  // Every accepted command yields a result beat next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("missing result beat");

  // A returned entry is never flagged as an error
  a_pop_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_pop_valid |-> out_strobe && !out_error)
    else $error("pop result with error");

  // A successful pop shrank the queue by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ok |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not shrink queue");
`endif

endmodule

### tb/spq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_checker: result checker for the stable priority queue
// Watches the command and result channels and keeps its own sorted copy of
// the queue. Every accepted command yields one predicted result beat, and
// each result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH          = DEPTH_DEF,
  parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic                             in_kind,
  input  logic signed [PRIORITY_WIDTH-1:0] in_priority_req,
  input  logic        [VALUE_WIDTH-1:0]    in_value,
  input  logic                             out_strobe,
  input  logic                             out_pop_valid,
  input  logic signed [PRIORITY_WIDTH-1:0] out_priority,
  input  logic        [VALUE_WIDTH-1:0]    out_value,
  input  logic                             out_empty_res,
  input  logic                             out_full_res,
  input  logic                             out_error,
  output int                               results_due,
  output int                               fail_count
);

  typedef struct packed {
    logic                             pop_valid;
    logic signed [PRIORITY_WIDTH-1:0] pri;
    logic        [VALUE_WIDTH-1:0]    val;
    logic                             empty;
    logic                             full;
    logic                             error;
  } spq_result_t;

  // Shadow copy of the sorted store, front entry at index 0
  logic signed [PRIORITY_WIDTH-1:0] held_pri [DEPTH];
  logic        [VALUE_WIDTH-1:0]    held_val [DEPTH];
  int                               held_count;

  spq_result_t due_results [$];
  int          fails;

  // Applies one command to the shadow queue and returns the result it makes
  function automatic spq_result_t apply_command(spq_kind_t kind,
                                                logic signed [PRIORITY_WIDTH-1:0] pri,
                                                logic [VALUE_WIDTH-1:0] val);
    spq_result_t r;
    int          pos;
    int          i;
    r = '0;
    if (kind == KIND_INSERT) begin
      if (held_count >= DEPTH) begin
        r.error = 1'b1;
      end else begin
        // new entry goes behind every entry of lower or equal priority
        pos = 0;
        while (pos < held_count && held_pri[pos] <= pri) pos++;
        for (i = held_count; i > pos; i--) begin
          held_pri[i] = held_pri[i-1];
          held_val[i] = held_val[i-1];
        end
        held_pri[pos] = pri;
        held_val[pos] = val;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.error = 1'b1;
      end else begin
        r.pop_valid = 1'b1;
        r.pri       = held_pri[0];
        r.val       = held_val[0];
        for (i = 1; i < held_count; i++) begin
          held_pri[i-1] = held_pri[i];
          held_val[i-1] = held_val[i];
        end
        held_count--;
      end
    end
    r.empty = (held_count == 0);
    r.full  = (held_count >= DEPTH);
    return r;
  endfunction

  task automatic check_field(string field, logic signed [63:0] exp_v,
                             logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, act_v);
      fails++;
    end
  endtask

  // Predict on each accepted command, then check any result beat
  always @(posedge clk) begin
    spq_result_t exp_r;
    if (!rst_n) begin
      held_count = 0;
      due_results.delete();
    end else begin
      if (start && !busy)
        due_results.push_back(apply_command(spq_kind_t'(in_kind), in_priority_req,
                                            in_value));
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          $error("result beat with no command outstanding");
          fails++;
        end else begin
          exp_r = due_results.pop_front();
          check_field("pop_valid", exp_r.pop_valid, out_pop_valid);
          check_field("out_priority", exp_r.pri, out_priority);
          check_field("out_value", {1'b0, exp_r.val}, {1'b0, out_value});
          check_field("empty_res", exp_r.empty, out_empty_res);
          check_field("full_res", exp_r.full, out_full_res);
          check_field("error", exp_r.error, out_error);
        end
      end
    end
    results_due <= due_results.size();
    fail_count  <= fails;
  end

endmodule

### tb/stable_priority_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: testbench top for the stable priority queue
// Drives a directed command sequence (empty pop, extreme and tied priorities,
// insert into a full queue) and then random insert/pop runs biased to fill
// and drain the queue. Checking is done by spq_checker beside the DUT.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 1325;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 start;
  logic                                 busy;
  logic                                 in_kind;
  logic signed [PRIORITY_WIDTH_DEF-1:0] in_priority_req;
  logic        [VALUE_WIDTH_DEF-1:0]    in_value;
  logic                                 out_strobe;
  logic                                 out_pop_valid;
  logic signed [PRIORITY_WIDTH_DEF-1:0] out_priority;
  logic        [VALUE_WIDTH_DEF-1:0]    out_value;
  logic                                 out_empty_res;
  logic                                 out_full_res;
  logic                                 out_error;
  int                                   results_due;
  int                                   fail_count;
  int                                   idle_pct;

  stable_priority_queue DUT (.*);

  spq_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the queue hangs
  initial begin
    #2000000;
    $display("stable_priority_queue_tb NOT OK");
    $finish;
  end

  // One command beat, with random idle cycles ahead of it
  task automatic send_cmd(spq_kind_t kind, logic signed [PRIORITY_WIDTH_DEF-1:0] pri,
                          logic [VALUE_WIDTH_DEF-1:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      start           <= 1'b0;
      in_kind         <= 1'($urandom_range(0, 1));
      in_priority_req <= PRIORITY_WIDTH_DEF'($urandom);
      in_value        <= $urandom;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_kind         <= kind;
    in_priority_req <= pri;
    in_value        <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Mix of tie-heavy, extreme and full-range priorities
  function automatic logic signed [PRIORITY_WIDTH_DEF-1:0] pick_priority();
    logic signed [PRIORITY_WIDTH_DEF-1:0] p;
    case ($urandom_range(0, 4))
      0, 1: begin
        p = PRIORITY_WIDTH_DEF'($urandom_range(0, 4));
        p = p - 16'sd2;
      end
      2: begin
        case ($urandom_range(0, 3))
          0: p = 16'sh8000;
          1: p = 16'sh7fff;
          2: p = 16'sh8001;
          default: p = 16'sh7ffe;
        endcase
      end
      default: p = PRIORITY_WIDTH_DEF'($urandom);
    endcase
    return p;
  endfunction

  // Stimulus
  initial begin
    logic signed [PRIORITY_WIDTH_DEF-1:0] fill_pri [16];
    logic        [VALUE_WIDTH_DEF-1:0]    fill_val;
    spq_kind_t                            kind;
    int                                   sent;
    int                                   run_len;
    int                                   ins_pct;
    int                                   i;
    int                                   k;
    fill_pri = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, -16'sd1, 16'sd1, 16'sd0, 16'sh8000,
                 16'sh7fff, 16'sd100, -16'sd100, 16'sd5, 16'sd5, -16'sd5, 16'sd2, 16'sd3};
    rst_n           = 1'b0;
    start           = 1'b0;
    in_kind         = KIND_INSERT;
    in_priority_req = '0;
    in_value        = '0;
    idle_pct        = 30;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pop, fill with extremes and ties, full insert, drain part
    send_cmd(KIND_POP, '0, '0);
    for (i = 0; i < 16; i++) begin
      fill_val = (i == 0) ? '1 : (i == 1) ? '0 : $urandom;
      send_cmd(KIND_INSERT, fill_pri[i], fill_val);
    end
    send_cmd(KIND_INSERT, 16'sh8000, $urandom);
    for (i = 0; i < 7; i++) send_cmd(KIND_POP, PRIORITY_WIDTH_DEF'($urandom), $urandom);

    // Random runs that each fill, drain or churn the queue
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      run_len = $urandom_range(8, 48);
      case ($urandom_range(0, 2))
        0: ins_pct = 85;
        1: ins_pct = 15;
        default: ins_pct = 50;
      endcase
      for (k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
        idle_pct = (sent >= 500 && sent < 800) ? 0 : 30;
        kind = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_POP;
        send_cmd(kind, pick_priority(), $urandom);
        sent++;
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then give the verdict
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("stable_priority_queue_tb OK");
    end else begin
      $display("stable_priority_queue_tb NOT OK");
    end
    $finish;
  end

endmodule
